/* hw/rtl/srw_pkg.sv */
// Shared types and constants for the serial register watchdog.
// Item structs, event codes, window offsets and parameter defaults.
// No dependencies.
package srw_pkg;

    // Parameter defaults
    localparam int WindowSizeDefault = 12;
    localparam int CountBitsDefault  = 32;

    // Event codes carried in the mode field
    localparam logic [2:0] ModeTick       = 3'd0;
    localparam logic [2:0] ModeWriteMatch = 3'd1;
    localparam logic [2:0] ModeReadMatch  = 3'd2;
    localparam logic [2:0] ModeDataWrite  = 3'd3;
    localparam logic [2:0] ModeDataRead   = 3'd4;
    localparam logic [2:0] ModeStop       = 3'd5;

    // Register window byte offsets
    localparam int OffEnable  = 1;
    localparam int OffReload  = 2;
    localparam int OffTimeout = 4;   // 4..7, word slot 1
    localparam int OffCounter = 8;   // 8..11, word slot 2

    typedef struct packed {
        logic [2:0] mode;
        logic [7:0] write_byte;
    } cmd_item_t;

    typedef struct packed {
        logic [7:0] read_byte;
        logic       chip_reset;
    } rsp_item_t;

endpackage

/* hw/rtl/srw_core.sv */
// Watchdog state and register window decode for the serial register watchdog.
// Computes one result per event and updates state on the accepting edge.
// Depends on srw_pkg.
module srw_core #(
    parameter int WINDOW_SIZE = srw_pkg::WindowSizeDefault,
    parameter int COUNT_BITS  = srw_pkg::CountBitsDefault
) (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  take,
    input  srw_pkg::cmd_item_t    cmd,
    output srw_pkg::rsp_item_t    rsp
);

    localparam int PtrBits = $clog2(WINDOW_SIZE);
    localparam logic [COUNT_BITS-1:0] CntOnes = {COUNT_BITS{1'b1}};

    logic                  pending_reg,  pending_next;
    logic [PtrBits-1:0]    ptr_reg,      ptr_next;
    logic [7:0]            enable_reg,   enable_next;
    logic [COUNT_BITS-1:0] live_reg,     live_next;
    logic [COUNT_BITS-1:0] count_reg,    count_next;
    logic [COUNT_BITS-1:0] staging_reg,  staging_next;
    logic [COUNT_BITS-1:0] snap_reg,     snap_next;

    // pointer byte modulo window size, as a constant lookup
    logic [PtrBits-1:0] mod_tab [256];
    genvar g;
    generate
        for (g = 0; g < 256; g++)
        begin : g_mod
            assign mod_tab[g] = PtrBits'(g % WINDOW_SIZE);
        end
    endgenerate

    logic [PtrBits-1:0] ptr_inc;
    logic               at_enable, at_reload, at_timeout, at_counter;
    logic [4:0]         lane_bit;
    logic [31:0]        staging_w, snap_w, staging_wr;

    assign ptr_inc    = (ptr_reg == PtrBits'(WINDOW_SIZE - 1)) ? '0 : ptr_reg + 1'b1;
    assign at_enable  = (ptr_reg == PtrBits'(srw_pkg::OffEnable));
    assign at_reload  = (ptr_reg == PtrBits'(srw_pkg::OffReload));
    assign at_timeout = (ptr_reg[PtrBits-1:2] == (PtrBits-2)'(srw_pkg::OffTimeout / 4));
    assign at_counter = (ptr_reg[PtrBits-1:2] == (PtrBits-2)'(srw_pkg::OffCounter / 4));
    assign lane_bit   = {ptr_reg[1:0], 3'b000};
    assign staging_w  = 32'(staging_reg);
    assign snap_w     = 32'(snap_reg);

    always_comb
    begin
        staging_wr = staging_w;
        staging_wr[lane_bit +: 8] = cmd.write_byte;
    end

    always_comb
    begin
        pending_next  = pending_reg;
        ptr_next      = ptr_reg;
        enable_next   = enable_reg;
        live_next     = live_reg;
        count_next    = count_reg;
        staging_next  = staging_reg;
        snap_next     = snap_reg;
        rsp.read_byte  = 8'h00;
        rsp.chip_reset = 1'b0;
        case (cmd.mode)
            srw_pkg::ModeTick:
            begin
                if (enable_reg != 8'h00)
                begin
                    if (count_reg == '0)
                    begin
                        // expiry: pulse and return to reset values
                        rsp.chip_reset = 1'b1;
                        pending_next   = 1'b0;
                        ptr_next       = '0;
                        enable_next    = 8'h00;
                        live_next      = CntOnes;
                        count_next     = CntOnes;
                        staging_next   = CntOnes;
                        snap_next      = CntOnes;
                    end
                    else
                    begin
                        count_next = count_reg - 1'b1;
                    end
                end
            end
            srw_pkg::ModeWriteMatch:
            begin
                pending_next = 1'b1;
            end
            srw_pkg::ModeReadMatch:
            begin
                staging_next = live_reg;
                snap_next    = count_reg;
            end
            srw_pkg::ModeDataWrite:
            begin
                if (pending_reg)
                begin
                    ptr_next     = mod_tab[cmd.write_byte];
                    pending_next = 1'b0;
                end
                else
                begin
                    if (at_enable)
                        enable_next = cmd.write_byte;
                    else if (at_reload)
                        count_next = live_reg;
                    else if (at_timeout)
                        staging_next = COUNT_BITS'(staging_wr);
                    ptr_next = ptr_inc;
                end
            end
            srw_pkg::ModeDataRead:
            begin
                if (at_enable)
                    rsp.read_byte = enable_reg;
                else if (at_timeout)
                    rsp.read_byte = staging_w[lane_bit +: 8];
                else if (at_counter)
                    rsp.read_byte = snap_w[lane_bit +: 8];
                ptr_next = ptr_inc;
            end
            srw_pkg::ModeStop:
            begin
                live_next = staging_reg;
            end
            default:
            begin
                // unused codes: no effect
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pending_reg <= 1'b0;
            ptr_reg     <= '0;
            enable_reg  <= 8'h00;
            live_reg    <= CntOnes;
            count_reg   <= CntOnes;
            staging_reg <= CntOnes;
            snap_reg    <= CntOnes;
        end
        else if (take)
        begin
            pending_reg <= pending_next;
            ptr_reg     <= ptr_next;
            enable_reg  <= enable_next;
            live_reg    <= live_next;
            count_reg   <= count_next;
            staging_reg <= staging_next;
            snap_reg    <= snap_next;
        end
    end

endmodule

/* hw/rtl/serial_register_watchdog_unit.sv */
// Throughput 1 item per cycle, held off only while the output register keeps a
// stalled result.
// Each item is applied to the watchdog state in its accepting cycle and its result
// lands in a single output register. Depends on srw_pkg and srw_core.
// Reset (rst_n low, async) empties the output register, disables the watchdog and
// loads timeout, counter, staging and snapshot with all ones.
module serial_register_watchdog_unit #(
    parameter int WINDOW_SIZE = srw_pkg::WindowSizeDefault,
    parameter int COUNT_BITS  = srw_pkg::CountBitsDefault
) (
    input  logic               clk,
    input  logic               rst_n,
    // event channel
    input  logic               cmd_valid,
    output logic               cmd_stall,
    input  srw_pkg::cmd_item_t cmd_item,
    // result channel
    output logic               rsp_valid,
    input  logic               rsp_stall,
    output srw_pkg::rsp_item_t rsp_item
);

    logic               take;
    srw_pkg::rsp_item_t rsp_comb;
    srw_pkg::rsp_item_t rsp_reg;
    logic               rsp_valid_reg, rsp_valid_next;

    // Hold off new items only while a result sits unaccepted downstream.
    assign cmd_stall = rsp_valid_reg & rsp_stall;
    assign take      = cmd_valid & ~cmd_stall;

    srw_core #(
        .WINDOW_SIZE (WINDOW_SIZE),
        .COUNT_BITS  (COUNT_BITS)
    ) u_core (
        .clk   (clk),
        .rst_n (rst_n),
        .take  (take),
        .cmd   (cmd_item),
        .rsp   (rsp_comb)
    );

    // Output register: refills when empty or drained this cycle.
    always_comb
    begin
        rsp_valid_next = rsp_valid_reg;
        if (take)
            rsp_valid_next = 1'b1;
        else if (!rsp_stall)
            rsp_valid_next = 1'b0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            rsp_valid_reg <= 1'b0;
        else
            rsp_valid_reg <= rsp_valid_next;
    end

    // payload needs no reset
    always_ff @(posedge clk)
    begin
        if (take)
            rsp_reg <= rsp_comb;
    end

    assign rsp_valid = rsp_valid_reg;
    assign rsp_item  = rsp_reg;

endmodule
